### hdl/stb_pkg.sv
package stb_pkg;

    // Default bank size
    localparam int NUM_TIMERS_DEF = 16;

    // Field widths
    localparam int SLOT_W    = 4;
    localparam int TARGET_W  = 4;
    localparam int SIGNAL_W  = 8;
    localparam int TIMEOUT_W = 32;

    // Stream widths
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;

    // Operation codes carried in s_axis_tuser
    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // State of one timer slot
    typedef struct packed {
        logic                 armed;
        logic [TIMEOUT_W-1:0] remaining;
        logic [TIMEOUT_W-1:0] reload_value;
        logic [TARGET_W-1:0]  target;
        logic [SIGNAL_W-1:0]  signal_id;
    } stb_slot_t;

    // Command held for the duration of one pass around the ring
    typedef struct packed {
        logic                 tick;
        logic                 slot_hit;
        logic [TARGET_W-1:0]  target;
        logic [SIGNAL_W-1:0]  signal_id;
        logic [TIMEOUT_W-1:0] timeout;
        logic                 repeat_req;
    } stb_cmd_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAP,
        ST_FLUSH
    } stb_state_t;

endpackage

### hdl/stb_cell.sv
module stb_cell
    import stb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  stb_slot_t din,
    output stb_slot_t dout
);

    stb_slot_t slot_reg;

    // Take the neighbor's slot state on each ring step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (advance)
        begin
            slot_reg <= din;
        end
    end

    assign dout = slot_reg;

endmodule

### hdl/stb_update.sv
module stb_update
    import stb_pkg::*;
(
    input  stb_cmd_t  cmd,
    input  stb_slot_t head,
    output stb_slot_t updated,
    output logic      fire
);

    logic [TIMEOUT_W-1:0] dec;

    assign dec = head.remaining - TIMEOUT_W'(1);

    // Count down on a tick, or rewrite the addressed slot on a set
    always_comb
    begin
        updated = head;
        fire    = 1'b0;
        if (cmd.tick)
        begin
            if (head.armed && (head.remaining != '0))
            begin
                if (dec == '0)
                begin
                    fire                 = 1'b1;
                    updated.remaining    = head.reload_value;
                    updated.armed        = (head.reload_value != '0);
                end
                else
                begin
                    updated.remaining = dec;
                end
            end
        end
        else if (cmd.slot_hit)
        begin
            if (cmd.timeout == '0)
            begin
                updated.armed        = 1'b0;
                updated.remaining    = '0;
                updated.reload_value = '0;
            end
            else
            begin
                updated.armed        = 1'b1;
                updated.target       = cmd.target;
                updated.signal_id    = cmd.signal_id;
                updated.remaining    = cmd.timeout;
                updated.reload_value = cmd.repeat_req ? cmd.timeout : '0;
            end
        end
    end

endmodule

### hdl/software_timer_bank.sv
// Channel  Direction  tdata fields (low bit up)                       tuser / tlast
// s_axis   in         slot, target_ao, signal_id, timeout, repeat_req  tuser = opcode
// m_axis   out        fired_slot, event_ao, event_signal              tlast = last
//
// Every item is taken in the idle state, then makes one lap of the slot ring
// (rotating all slots through the single update unit), and then hands off
// any final expiry in the flush state.
// The ring pauses whenever an expiry finds both the pending and output
// registers full. Reset clears every slot and all control state at once.
module software_timer_bank
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // slot[3:0], target_ao[7:4], signal_id[15:8], timeout[47:16], repeat_req[48]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // fired_slot[3:0], event_ao[7:4], event_signal[15:8]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = (IW > SLOT_W) ? IW : SLOT_W;

    stb_state_t state_reg, state_next;

    logic [IW-1:0]     pos_reg;
    logic              tick_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [TARGET_W-1:0]  tgt_reg;
    logic [SIGNAL_W-1:0]  sig_reg;
    logic [TIMEOUT_W-1:0] tmo_reg;
    logic                 rep_reg;

    logic                pend_valid_reg;
    logic [SLOT_W-1:0]   pend_slot_reg;
    logic [TARGET_W-1:0] pend_tgt_reg;
    logic [SIGNAL_W-1:0] pend_sig_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;

    logic [CW-1:0] pos_wide;
    logic          accept;
    logic          out_free;
    logic          advance;
    logic          push_out;
    logic          push_last;
    logic          take_new;

    stb_cmd_t  cmd;
    stb_slot_t head;
    stb_slot_t updated;
    logic      fire;
    stb_slot_t ring_in  [NUM_TIMERS];
    stb_slot_t ring_out [NUM_TIMERS];

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign pos_wide = CW'(pos_reg);

    // Assemble the command seen by the update unit
    always_comb
    begin
        cmd.tick       = tick_reg;
        cmd.slot_hit   = (CW'(slot_reg) == pos_wide);
        cmd.target     = tgt_reg;
        cmd.signal_id  = sig_reg;
        cmd.timeout    = tmo_reg;
        cmd.repeat_req = rep_reg;
    end

    // Ring of slot cells; the last cell feeds the update unit, which feeds the first
    assign head = ring_out[NUM_TIMERS-1];

    genvar gi;
    generate
        for (gi = 0; gi < NUM_TIMERS; gi++)
        begin : g_ring
            if (gi == 0)
            begin : g_first
                assign ring_in[gi] = updated;
            end
            else
            begin : g_rest
                assign ring_in[gi] = ring_out[gi-1];
            end
            stb_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .din     (ring_in[gi]),
                .dout    (ring_out[gi])
            );
        end
    endgenerate

    stb_update u_update (
        .cmd     (cmd),
        .head    (head),
        .updated (updated),
        .fire    (fire)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LAP;
                end
            end
            ST_LAP:
            begin
                if (advance && (pos_reg == IW'(NUM_TIMERS - 1)))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        advance       = 1'b0;
        push_out      = 1'b0;
        push_last     = 1'b0;
        take_new      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_LAP:
            begin
                if (!(fire && pend_valid_reg && !out_free))
                begin
                    advance = 1'b1;
                    if (fire)
                    begin
                        take_new = 1'b1;
                        push_out = pend_valid_reg;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg && out_free)
                begin
                    push_out  = 1'b1;
                    push_last = 1'b1;
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                pos_reg <= '0;
            end
            else if (advance)
            begin
                pos_reg <= IW'(pos_reg + IW'(1));
            end
            if (take_new)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (push_out)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (push_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Latch the command, the pending expiry and the output transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tick_reg <= (s_axis_tuser == OP_TICK);
            slot_reg <= s_axis_tdata[3:0];
            tgt_reg  <= s_axis_tdata[7:4];
            sig_reg  <= s_axis_tdata[15:8];
            tmo_reg  <= s_axis_tdata[47:16];
            rep_reg  <= s_axis_tdata[48];
        end
        if (take_new)
        begin
            pend_slot_reg <= pos_wide[SLOT_W-1:0];
            pend_tgt_reg  <= head.target;
            pend_sig_reg  <= head.signal_id;
        end
        if (push_out)
        begin
            out_data_reg <= {pend_sig_reg, pend_tgt_reg, pend_slot_reg};
            out_last_reg <= push_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### hdl/stb_checker.sv
module stb_checker
    import stb_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    // Hold a stalled output transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transfer changed while stalled");

    // Drop ready for the lap after any accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted during a lap");

    // Produce results only while an item is being worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while idle");

    // A set item starts no result in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_SET) |=>
            !$rose(m_axis_tvalid))
    else $error("set item produced a result");

endmodule

bind software_timer_bank stb_checker u_stb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### bench/tb_software_timer_bank.sv
module tb_software_timer_bank;

    import stb_pkg::*;

    localparam int SETTLE_CYCLES = 2 * NUM_TIMERS_DEF + 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 360;

    // One expiry as it leaves the block
    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [TARGET_W-1:0] ao;
        logic [SIGNAL_W-1:0] sig;
        logic                last;
    } expiry_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // slot[3:0], target_ao[7:4], signal_id[15:8], timeout[47:16], repeat_req[48]
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // opcode[0]
    logic                  s_axis_tuser = OP_SET;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // fired_slot[3:0], event_ao[7:4], event_signal[15:8]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // Shadow of the timer bank
    logic                 bank_armed  [NUM_TIMERS_DEF];
    logic [TIMEOUT_W-1:0] bank_count  [NUM_TIMERS_DEF];
    logic [TIMEOUT_W-1:0] bank_reload [NUM_TIMERS_DEF];
    logic [TARGET_W-1:0]  bank_target [NUM_TIMERS_DEF];
    logic [SIGNAL_W-1:0]  bank_signal [NUM_TIMERS_DEF];

    expiry_t expiry_q[$];
    expiry_t want;

    int err_count     = 0;
    int burst_left    = 0;
    int quiet_cycles  = 0;
    int rx_cycle      = 0;
    int hold_left     = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int n_items       = 0;
    int n_ticks       = 0;
    int n_clears      = 0;
    int n_expiries    = 0;
    int max_per_tick  = 0;

    software_timer_bank dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [IN_DATA_W-1:0] pack_item(logic [SLOT_W-1:0] slot,
                                                       logic [TARGET_W-1:0] target,
                                                       logic [SIGNAL_W-1:0] sig,
                                                       logic [TIMEOUT_W-1:0] timeout,
                                                       logic rep);
        return {7'b0, rep, timeout, sig, target, slot};
    endfunction

    // Update the shadow bank for one transfer and queue the expiries it causes
    function automatic void apply_item(logic op, logic [IN_DATA_W-1:0] data);
        int      slot;
        int      n;
        expiry_t hits[NUM_TIMERS_DEF];
        logic [TIMEOUT_W-1:0] timeout;
        slot    = int'(data[3:0]);
        timeout = data[47:16];
        n       = 0;
        n_items++;
        if (op == OP_SET) begin
            if (slot < NUM_TIMERS_DEF) begin
                if (timeout == '0) begin
                    n_clears++;
                    bank_armed[slot]  = 1'b0;
                    bank_count[slot]  = '0;
                    bank_reload[slot] = '0;
                end
                else begin
                    bank_armed[slot]  = 1'b1;
                    bank_target[slot] = data[7:4];
                    bank_signal[slot] = data[15:8];
                    bank_count[slot]  = timeout;
                    bank_reload[slot] = data[48] ? timeout : '0;
                end
            end
        end
        else begin
            n_ticks++;
            for (int i = 0; i < NUM_TIMERS_DEF; i++) begin
                if (bank_armed[i] && bank_count[i] != '0) begin
                    bank_count[i] = bank_count[i] - TIMEOUT_W'(1);
                    if (bank_count[i] == '0) begin
                        hits[n].slot = SLOT_W'(i);
                        hits[n].ao   = bank_target[i];
                        hits[n].sig  = bank_signal[i];
                        hits[n].last = 1'b0;
                        n++;
                        bank_count[i] = bank_reload[i];
                        if (bank_reload[i] == '0)
                            bank_armed[i] = 1'b0;
                    end
                end
            end
            for (int k = 0; k < n; k++) begin
                hits[k].last = (k == n - 1);
                expiry_q.push_back(hits[k]);
            end
            if (n > max_per_tick)
                max_per_tick = n;
        end
    endfunction

    // Offer one item in bursts with random gaps, hold it until the transfer
    task automatic send_item(input logic op, input logic [IN_DATA_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        apply_item(op, data);
    endtask

    // Tick with random content in the unused fields
    task automatic send_tick();
        send_item(OP_TICK, pack_item(SLOT_W'($urandom_range(0, 15)),
                                     TARGET_W'($urandom_range(0, 15)),
                                     SIGNAL_W'($urandom_range(0, 255)), $urandom,
                                     1'($urandom_range(0, 1))));
    endtask

    // Stop offering and wait until every queued expiry has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expiry_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input int exp_val, input int got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            err_count++;
        end
    endtask

    task automatic test_idle_tick();
        send_tick();
        wait_drained();
    endtask

    // Arm every slot for one tick, odd slots repeating, field extremes at the ends
    task automatic test_full_bank();
        for (int s = 0; s < NUM_TIMERS_DEF; s++)
            send_item(OP_SET, pack_item(SLOT_W'(s), TARGET_W'(15 - s),
                                        SIGNAL_W'(255 - s * 17), TIMEOUT_W'(1), s[0]));
        send_tick();
        send_tick();
        wait_drained();
    endtask

    // Re-arm an armed slot with new values and clear a repeating slot
    task automatic test_clear_and_rearm();
        send_item(OP_SET, pack_item(SLOT_W'(3), 4'h6, 8'h5A, 32'hFFFF_FFFF, 1'b1));
        send_item(OP_SET, pack_item(SLOT_W'(3), 4'h9, 8'hA5, TIMEOUT_W'(2), 1'b0));
        send_item(OP_SET, pack_item(SLOT_W'(1), 4'hF, 8'hFF, TIMEOUT_W'(0), 1'b1));
        send_tick();
        send_tick();
        wait_drained();
    endtask

    // Hold the output off while repeating slots keep expiring every tick or every second tick
    task automatic test_backpressure();
        hold_seq <= hold_seq + 1;
        for (int i = 0; i < 8; i++)
            send_item(OP_SET, pack_item(SLOT_W'($urandom_range(0, 15)),
                                        TARGET_W'($urandom_range(0, 15)),
                                        SIGNAL_W'($urandom_range(0, 255)),
                                        TIMEOUT_W'($urandom_range(1, 2)),
                                        1'b1));
        for (int i = 0; i < 30; i++)
            send_tick();
        wait_drained();
    endtask

    task automatic test_random();
        int pick;
        logic [TIMEOUT_W-1:0] timeout;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 9) < 4) begin
                send_tick();
            end
            else begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    timeout = '0;
                else if (pick == 1)
                    timeout = $urandom;
                else
                    timeout = $urandom_range(1, 6);
                send_item(OP_SET, pack_item(SLOT_W'($urandom_range(0, 15)),
                                            TARGET_W'($urandom_range(0, 15)),
                                            SIGNAL_W'($urandom_range(0, 255)), timeout,
                                            1'($urandom_range(0, 1))));
            end
        end
        wait_drained();
    endtask

    // Receiver: long hold-off on request, otherwise a rotating stall pattern
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (hold_seq != hold_seen) begin
            hold_seen     <= hold_seq;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else begin
            case ((rx_cycle / 50) % 4)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 0);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Compare each output transfer with the oldest queued expiry
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expiry_q.size() == 0) begin
                $error("unexpected expiry: slot %0d, ao %0d, signal %0d, last %0d",
                       m_axis_tdata[3:0], m_axis_tdata[7:4], m_axis_tdata[15:8],
                       m_axis_tlast);
                err_count++;
            end
            else begin
                want = expiry_q.pop_front();
                n_expiries++;
                check_field("fired_slot", int'(want.slot), int'(m_axis_tdata[3:0]));
                check_field("event_ao", int'(want.ao), int'(m_axis_tdata[7:4]));
                check_field("event_signal", int'(want.sig), int'(m_axis_tdata[15:8]));
                check_field("last", int'(want.last), int'(m_axis_tlast));
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout after %0d cycles without a transfer", quiet_cycles);
                $display("[software_timer_bank] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < NUM_TIMERS_DEF; i++) begin
            bank_armed[i]  = 1'b0;
            bank_count[i]  = '0;
            bank_reload[i] = '0;
            bank_target[i] = '0;
            bank_signal[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_tick();
        test_full_bank();
        test_clear_and_rearm();
        test_backpressure();
        test_random();

        $display("Ran %0d items: %0d ticks, %0d sets (%0d clears).",
                 n_items, n_ticks, n_items - n_ticks, n_clears);
        $display("Checked %0d expiries, up to %0d from a single tick.",
                 n_expiries, max_per_tick);
        if (err_count == 0)
            $display("[software_timer_bank] OK");
        else
            $display("[software_timer_bank] ERROR");
        $finish;
    end

endmodule

### filelist.f
hdl/stb_pkg.sv
hdl/stb_cell.sv
hdl/stb_update.sv
hdl/software_timer_bank.sv
hdl/stb_checker.sv
bench/tb_software_timer_bank.sv
